@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

@@ rtl/core/lru_pkg.sv @@
`timescale 1ns / 1ps

package lru_pkg;

    localparam int FRAMES_DEF = 16;
    localparam int PAGE_W     = 8;
    localparam int RANK_W     = 4;
    localparam int IDX_OUT_W  = 4;
    localparam int CFG_W      = 5;

    localparam logic [CFG_W-1:0]  CFG_RESET = 5'd16;
    localparam logic [RANK_W-1:0] RANK_MAX  = 4'd15;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_AGE,
        ST_AGE_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic scan_rd;
        logic age_rd;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic idx_last;
        logic out_free;
    } stat_t;

endpackage

@@ rtl/core/lru_if.sv @@
`timescale 1ns / 1ps

interface lru_page_if;
    import lru_pkg::*;

    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] page_id;

    modport source (output valid, output page_id, input ready);
    modport sink (input valid, input page_id, output ready);
endinterface

interface lru_result_if;
    import lru_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [IDX_OUT_W-1:0] frame_index;
    logic                 filled_empty;

    modport source (output valid, output hit, output frame_index, output filled_empty,
                    input ready);
    modport sink (input valid, input hit, input frame_index, input filled_empty,
                  output ready);
endinterface

interface lru_cfg_if;
    import lru_pkg::*;

    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/lru_ram.sv @@
`timescale 1ns / 1ps

module lru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/lru_ctrl.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lru_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  lru_pkg::stat_t stat,
    output lru_pkg::cmd_t  cmd
);
    import lru_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.idx_last)
                begin
                    state_next = ST_SCAN_WAIT;
                end
            end
            ST_SCAN_WAIT:
            begin
                state_next = ST_AGE;
            end
            ST_AGE:
            begin
                if (stat.idx_last)
                begin
                    state_next = ST_AGE_WAIT;
                end
            end
            ST_AGE_WAIT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = in_valid;
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
            end
            ST_AGE:
            begin
                cmd.age_rd = 1'b1;
            end
            ST_DONE:
            begin
                cmd.finish = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    `ASSERT_CLK(a_cmd_onehot, clk, rst_n, $onehot0(cmd), "more than one command at once")
    `ASSERT_CLK(a_start_scan, clk, rst_n, cmd.start |=> cmd.scan_rd, "scan did not follow start")
    `ASSERT_CLK(a_scan_end, clk, rst_n, (cmd.scan_rd && stat.idx_last) |=> !cmd.scan_rd,
                "scan ran past the last frame")

endmodule

@@ rtl/core/lru_dpath.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lru_dpath #(
    parameter int FRAMES = lru_pkg::FRAMES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [lru_pkg::PAGE_W-1:0]    page_id,
    input  logic                          cfg_we,
    input  logic [lru_pkg::CFG_W-1:0]     cfg_data,
    input  lru_pkg::cmd_t                 cmd,
    output lru_pkg::stat_t                stat,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          out_hit,
    output logic [lru_pkg::IDX_OUT_W-1:0] out_frame_index,
    output logic                          out_filled_empty
);
    import lru_pkg::*;

    localparam int IW    = $clog2(FRAMES);
    localparam int CNT_W = ($clog2(FRAMES + 1) > CFG_W) ? $clog2(FRAMES + 1) : CFG_W;
    localparam int WORD_W = RANK_W + PAGE_W;

    logic [CFG_W-1:0]  fiu_reg;
    logic [FRAMES-1:0] valid_reg;
    logic              out_valid_reg;

    logic [PAGE_W-1:0] page_reg;
    logic [IW-1:0]     last_reg;
    logic [IW-1:0]     idx_reg;
    logic [IW-1:0]     rd_idx_reg;
    logic              pend_scan_reg;
    logic              pend_age_reg;
    logic              hit_found_reg;
    logic [IW-1:0]     hit_idx_reg;
    logic [RANK_W-1:0] hit_rank_reg;
    logic              empty_found_reg;
    logic [IW-1:0]     empty_idx_reg;
    logic [IW-1:0]     best_idx_reg;
    logic [RANK_W-1:0] best_rank_reg;
    logic              out_hit_reg;
    logic [IDX_OUT_W-1:0] out_idx_reg;
    logic              out_filled_reg;

    logic [CNT_W-1:0]  fiu_ext;
    logic [CNT_W-1:0]  cnt;
    logic [IW-1:0]     last_next;
    logic [WORD_W-1:0] rd_data;
    logic [RANK_W-1:0] rd_rank;
    logic [PAGE_W-1:0] rd_page;
    logic              rd_valid;
    logic [IW-1:0]     tgt;
    logic [RANK_W-1:0] old_rank;
    logic [RANK_W-1:0] new_rank;
    logic [PAGE_W-1:0] new_page;
    logic              rd_en;

    // The active frame count is clamped to one at the low end and to the table size.
    always_comb
    begin
        fiu_ext = CNT_W'(fiu_reg);
        cnt     = fiu_ext;
        if (fiu_ext == '0)
        begin
            cnt = CNT_W'(1);
        end
        else if (fiu_ext > CNT_W'(FRAMES))
        begin
            cnt = CNT_W'(FRAMES);
        end
        last_next = IW'(cnt - CNT_W'(1));
    end

    assign rd_en   = cmd.scan_rd | cmd.age_rd;
    assign rd_rank = rd_data[PAGE_W +: RANK_W];
    assign rd_page = rd_data[PAGE_W-1:0];
    assign rd_valid = valid_reg[rd_idx_reg];

    // Frame that this request touches and the rank it held before.
    always_comb
    begin
        if (hit_found_reg)
        begin
            tgt      = hit_idx_reg;
            old_rank = hit_rank_reg;
        end
        else if (empty_found_reg)
        begin
            tgt      = empty_idx_reg;
            old_rank = RANK_MAX;
        end
        else
        begin
            tgt      = best_idx_reg;
            old_rank = best_rank_reg;
        end
    end

    always_comb
    begin
        new_rank = rd_rank;
        new_page = rd_page;
        if (rd_idx_reg == tgt)
        begin
            new_rank = '0;
            new_page = page_reg;
        end
        else if (rd_valid && (rd_rank < old_rank) && (rd_rank != RANK_MAX))
        begin
            new_rank = rd_rank + RANK_W'(1);
        end
    end

    lru_ram #(
        .WIDTH(WORD_W),
        .DEPTH(FRAMES)
    ) u_frame_ram (
        .clk  (clk),
        .we   (pend_age_reg),
        .waddr(rd_idx_reg),
        .wdata({new_rank, new_page}),
        .re   (rd_en),
        .raddr(idx_reg),
        .rdata(rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fiu_reg       <= CFG_RESET;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            pend_scan_reg <= 1'b0;
            pend_age_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                fiu_reg <= cfg_data;
            end
            pend_scan_reg <= cmd.scan_rd;
            pend_age_reg  <= cmd.age_rd;
            if (cmd.finish && !hit_found_reg && empty_found_reg)
            begin
                valid_reg[empty_idx_reg] <= 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            page_reg        <= page_id;
            last_reg        <= last_next;
            idx_reg         <= '0;
            hit_found_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            if (idx_reg == last_reg)
            begin
                idx_reg <= '0;
            end
            else
            begin
                idx_reg <= idx_reg + IW'(1);
            end
        end
        if (rd_en)
        begin
            rd_idx_reg <= idx_reg;
        end
        if (pend_scan_reg)
        begin
            if (rd_valid && (rd_page == page_reg) && !hit_found_reg)
            begin
                hit_found_reg <= 1'b1;
                hit_idx_reg   <= rd_idx_reg;
                hit_rank_reg  <= rd_rank;
            end
            if (!rd_valid && !empty_found_reg)
            begin
                empty_found_reg <= 1'b1;
                empty_idx_reg   <= rd_idx_reg;
            end
            if ((rd_idx_reg == '0) || (rd_rank > best_rank_reg))
            begin
                best_idx_reg  <= rd_idx_reg;
                best_rank_reg <= rd_rank;
            end
        end
        if (cmd.finish)
        begin
            out_hit_reg    <= hit_found_reg;
            out_idx_reg    <= IDX_OUT_W'(tgt);
            out_filled_reg <= !hit_found_reg && empty_found_reg;
        end
    end

    assign stat.idx_last    = (idx_reg == last_reg);
    assign stat.out_free    = !out_valid_reg || out_ready;
    assign out_valid        = out_valid_reg;
    assign out_hit          = out_hit_reg;
    assign out_frame_index  = out_idx_reg;
    assign out_filled_empty = out_filled_reg;

    `ASSERT_CLK(a_finish_out, clk, rst_n, cmd.finish |=> out_valid_reg,
                "finished request did not reach the output")
    `ASSERT_NEVER(a_hit_fill, clk, rst_n, out_valid_reg && out_hit_reg && out_filled_reg,
                  "result reports both a hit and a fill")
    `ASSERT_CLK(a_idx_range, clk, rst_n, rd_en |-> (idx_reg <= last_reg),
                "frame walk beyond the active count")

endmodule

@@ rtl/core/lru_page_replacement.sv @@
`timescale 1ns / 1ps

// LRU page frame table. Each request on the page channel carries one page number and
// produces exactly one result: whether the page was resident, the frame that now holds it,
// and whether a miss filled an empty frame. A request walks the first N frames, where N
// is the active frame count from the configuration register (clamped to 1..FRAMES): the
// frame store sits in a single RAM that is walked once to find a hit, the first empty frame
// and the oldest frame, and walked again to age the ranks and write the touched frame. The
// result waits in an output register, so the next request is taken while it is pending.
// The configuration register is written through its own channel and should only be changed
// while no request is in flight.
module lru_page_replacement #(
    parameter int FRAMES = lru_pkg::FRAMES_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    lru_page_if.sink     page,
    lru_result_if.source result,
    lru_cfg_if.sink      cfg
);
    import lru_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  in_ready;

    assign page.ready = in_ready;
    assign cfg.ready  = 1'b1;

    lru_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(page.valid),
        .in_ready(in_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lru_dpath #(
        .FRAMES(FRAMES)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .page_id         (page.page_id),
        .cfg_we          (cfg.valid),
        .cfg_data        (cfg.data),
        .cmd             (cmd),
        .stat            (stat),
        .out_ready       (result.ready),
        .out_valid       (result.valid),
        .out_hit         (result.hit),
        .out_frame_index (result.frame_index),
        .out_filled_empty(result.filled_empty)
    );

endmodule

@@ verif/lru_page_replacement_test.sv @@
`timescale 1ns / 1ps

module lru_page_replacement_test;
    import lru_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int TARGET_REQUESTS = 1900;

    typedef struct {
        logic                 hit;
        logic [IDX_OUT_W-1:0] frame_index;
        logic                 filled_empty;
    } lru_outcome_t;

    // Tracks the frame table and the outcomes still owed by the block.
    class lru_frame_tracker;
        logic [PAGE_W-1:0] page_of [FRAMES_DEF];
        bit                valid_of [FRAMES_DEF];
        logic [RANK_W-1:0] rank_of [FRAMES_DEF];
        logic [CFG_W-1:0]  frames_reg;
        lru_outcome_t      awaited [$];
        int                mismatches;

        function void clear();
            for (int i = 0; i < FRAMES_DEF; i++)
            begin
                page_of[i] = '0;
                valid_of[i] = 1'b0;
                rank_of[i] = '0;
            end
            frames_reg = CFG_RESET;
            awaited.delete();
            mismatches = 0;
        endfunction

        function void set_frames(logic [CFG_W-1:0] value);
            frames_reg = value;
        endfunction

        function int active_frames();
            if (frames_reg == 0)
                return 1;
            if (frames_reg > FRAMES_DEF)
                return FRAMES_DEF;
            return int'(frames_reg);
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        // Frames younger than the touched one age by one step; the touched one becomes newest.
        function void promote(int t, logic [RANK_W-1:0] old_rank, int n);
            for (int i = 0; i < n; i++)
            begin
                if (i != t && valid_of[i] && rank_of[i] < old_rank && rank_of[i] < RANK_MAX)
                    rank_of[i] = rank_of[i] + 1'b1;
            end
            rank_of[t] = '0;
        endfunction

        function void note_page(logic [PAGE_W-1:0] pid);
            int n;
            int t;
            int best;
            bit found;
            lru_outcome_t res;
            n = active_frames();
            t = 0;
            found = 1'b0;
            res.hit = 1'b0;
            res.filled_empty = 1'b0;
            for (int i = 0; i < n; i++)
            begin
                if (!found && valid_of[i] && page_of[i] == pid)
                begin
                    t = i;
                    found = 1'b1;
                end
            end
            if (found)
            begin
                res.hit = 1'b1;
                promote(t, rank_of[t], n);
            end
            else
            begin
                for (int i = 0; i < n; i++)
                begin
                    if (!found && !valid_of[i])
                    begin
                        t = i;
                        found = 1'b1;
                    end
                end
                if (found)
                begin
                    res.filled_empty = 1'b1;
                    page_of[t] = pid;
                    valid_of[t] = 1'b1;
                    promote(t, RANK_MAX, n);
                end
                else
                begin
                    best = 0;
                    for (int i = 1; i < n; i++)
                    begin
                        if (rank_of[i] > rank_of[best])
                            best = i;
                    end
                    t = best;
                    page_of[t] = pid;
                    promote(t, rank_of[t], n);
                end
            end
            res.frame_index = IDX_OUT_W'(t);
            awaited.push_back(res);
        endfunction

        function void check_result(logic hit, logic [IDX_OUT_W-1:0] frame_index,
                                   logic filled_empty);
            lru_outcome_t want;
            if (awaited.size() == 0)
            begin
                $error("unexpected result: hit=%0b frame_index=%0d filled_empty=%0b",
                       hit, frame_index, filled_empty);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            if (hit !== want.hit)
            begin
                $error("hit: expected %0b, actual %0b", want.hit, hit);
                mismatches++;
            end
            if (frame_index !== want.frame_index)
            begin
                $error("frame_index: expected %0d, actual %0d", want.frame_index, frame_index);
                mismatches++;
            end
            if (filled_empty !== want.filled_empty)
            begin
                $error("filled_empty: expected %0b, actual %0b", want.filled_empty,
                       filled_empty);
                mismatches++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    lru_page_if   page_ch ();
    lru_result_if result_ch ();
    lru_cfg_if    cfg_ch ();

    lru_frame_tracker tracker;
    bit               tx_calm;
    bit               rx_calm;
    bit               rx_hold_req;
    int unsigned      cycle_count;

    lru_page_replacement dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .page   (page_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic offer_page(input logic [PAGE_W-1:0] pid);
        int gap;
        page_ch.valid <= 1'b1;
        page_ch.page_id <= pid;
        do
            @(posedge clk);
        while (!page_ch.ready);
        gap = pick_gap(tx_calm);
        if (gap > 0)
        begin
            page_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle();
        page_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.outstanding() != 0);
    endtask

    task automatic write_frames(input logic [CFG_W-1:0] value);
        settle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        tracker.set_frames(value);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (page_ch.valid && page_ch.ready)
                tracker.note_page(page_ch.page_id);
            if (result_ch.valid && result_ch.ready)
                tracker.check_result(result_ch.hit, result_ch.frame_index,
                                     result_ch.filled_empty);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : result_sink
        int stall;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = pick_gap(rx_calm);
                if (stall > 0)
                begin
                    result_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                result_ch.ready <= 1'b1;
                do
                    @(posedge clk);
                while (!result_ch.valid && !rx_hold_req);
            end
        end
    end

    initial
    begin : stimulus
        logic [CFG_W-1:0]  plan [9];
        logic [CFG_W-1:0]  setting;
        logic [PAGE_W-1:0] pool [$];
        logic [PAGE_W-1:0] pid;
        int                sent;
        int                phase;
        int                n;
        int                pool_size;
        int                burst;

        plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd8, 5'd17, 5'd15, 5'd3};
        rst_n = 1'b0;
        page_ch.valid = 1'b0;
        page_ch.page_id = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        cycle_count = 0;
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        rx_hold_req = 1'b0;
        tracker = new;
        tracker.clear();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fills, hits and extreme page numbers with the full table after reset.
        offer_page(8'h00);
        offer_page(8'hFF);
        offer_page(8'h00);
        offer_page(8'h80);
        offer_page(8'h01);
        offer_page(8'hFF);
        // A count of zero acts as one frame, so misses replace frame zero and a page held
        // only in an inactive frame misses.
        write_frames(5'd0);
        offer_page(8'h00);
        offer_page(8'h7F);
        offer_page(8'h7F);
        offer_page(8'hFF);
        // A count above the table size acts as the full table, and the duplicate page
        // resolves to the lowest frame.
        write_frames(5'd31);
        offer_page(8'hFF);
        // A small table after the count changed, with tied ranks.
        write_frames(5'd3);
        offer_page(8'h10);
        offer_page(8'h20);
        offer_page(8'h30);
        offer_page(8'h10);
        sent = 15;

        phase = 0;
        while (sent < TARGET_REQUESTS)
        begin
            if (phase < 9)
                setting = plan[phase];
            else
                setting = CFG_W'($urandom_range(0, 31));
            write_frames(setting);
            n = tracker.active_frames();
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            pool.delete();
            pool_size = $urandom_range(1, n + n / 2 + 2);
            repeat (pool_size) pool.push_back(PAGE_W'($urandom_range(0, 255)));
            burst = $urandom_range(30, 150);
            if (phase == 2)
            begin
                // The receiver stops for a long time while requests keep coming.
                tx_calm = 1'b1;
                rx_hold_req = 1'b1;
            end
            repeat (burst)
            begin
                if ($urandom_range(0, 4) == 0)
                    pid = PAGE_W'($urandom_range(0, 255));
                else
                    pid = pool[$urandom_range(0, pool.size() - 1)];
                offer_page(pid);
                sent++;
            end
            phase++;
        end

        settle();
        repeat (4 * FRAMES_DEF) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/lru_pkg.sv
rtl/core/lru_if.sv
rtl/core/lru_ram.sv
rtl/core/lru_ctrl.sv
rtl/core/lru_dpath.sv
rtl/core/lru_page_replacement.sv
verif/lru_page_replacement_test.sv
